// File: rtl/sbc_pkg.sv
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int MAX_VERTICES_DEF     = 1024;
  localparam int MAX_LIST_ENTRIES_DEF = 8192;

  localparam int CMD_W     = 2;
  localparam int VTX_W     = 10;
  localparam int STATUS_W  = 2;
  localparam int SCORE_W   = 48;
  localparam int COUNT_W   = 11;
  localparam int SCALE_W   = 27;
  localparam int CFG_IDX_W = 2;
  localparam int PATH_W    = 32;
  localparam int NUM_W     = 65;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 11'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RST        = 27'd65536;
  localparam logic [32:0]        DEP_ONE          = 33'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd1;

  typedef enum logic [1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_SOURCE   = 2'd1,
    CMD_READ     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SELF_LOOP = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_E_WA, S_E_WB, S_RD_W, S_CLR, S_SEED,
    S_B_POP, S_B_CUR, S_B_CURD, S_B_EDGE, S_B_NB, S_B_UPD,
    S_R_POP, S_R_W, S_R_WD, S_R_EDGE, S_R_NB, S_R_VD, S_R_MUL,
    S_R_ADD, S_R_DIV, S_R_DEP, S_R_SMUL, S_R_SCW, S_OUT
  } state_t;

endpackage

// File: rtl/sbc_ram.sv
`timescale 1ns / 1ps

module sbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/sbc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sbc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sbc_pkg::NUM_W-1:0]  num,
  input  logic [sbc_pkg::PATH_W-1:0] den,
  output logic                       done,
  output logic [sbc_pkg::NUM_W-1:0]  quo
);

  localparam int CW = $clog2(sbc_pkg::NUM_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [sbc_pkg::NUM_W-1:0]   num_r;
  logic [sbc_pkg::PATH_W:0]    rem_r;
  logic [sbc_pkg::PATH_W:0]    rem_sh;
  logic                        fits;

  always_comb begin
    rem_sh = {rem_r[sbc_pkg::PATH_W-1:0], num_r[sbc_pkg::NUM_W-1]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(sbc_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[sbc_pkg::NUM_W-2:0], fits};
      rem_r <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: rtl/sampled_betweenness_centrality.sv
`timescale 1ns / 1ps

// Sampled betweenness centrality engine. Command 0 adds an undirected edge
// (two list entries), command 1 runs a breadth-first search from a source
// vertex followed by a reverse dependency pass that adds to the score of
// each reached vertex other than the source, command 2 reads one score.
// Every item gives one result. After reset the block clears the adjacency
// heads and scores before it accepts the first item. A source first clears
// the per-source stores, then walks each reached vertex and its adjacency
// entries in the search, and in the reverse pass walks each reached vertex,
// its adjacency entries and its predecessor edges, using the bit-serial
// divider to compute each dependency term.
// All state sits in single-port-read memories, so the work is sequential.
module sampled_betweenness_centrality #(
  parameter int MAX_VERTICES     = sbc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_LIST_ENTRIES = sbc_pkg::MAX_LIST_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sbc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [sbc_pkg::VTX_W-1:0]     in_vertex_a,
  input  logic [sbc_pkg::VTX_W-1:0]     in_vertex_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sbc_pkg::STATUS_W-1:0]  out_status,
  output logic [sbc_pkg::SCORE_W-1:0]   out_score,
  output logic [sbc_pkg::COUNT_W-1:0]   out_reached_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbc_pkg::SCALE_W-1:0]   cfg_data
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int HW   = VW + 1;
  localparam int CNTW = VW + 1;
  localparam int PW   = $clog2(MAX_LIST_ENTRIES + 1);
  localparam int EW   = $clog2(MAX_LIST_ENTRIES);
  localparam logic [HW-1:0] HOP_NONE = {HW{1'b1}};

  sbc_pkg::state_t state_r, state_nxt;

  logic [sbc_pkg::COUNT_W-1:0] vertex_count_r;
  logic [sbc_pkg::SCALE_W-1:0] scale_r;
  logic [CNTW-1:0]             cnt_r;
  logic [CNTW-1:0]             tail_r;
  logic [PW-1:0]               ec_r;
  logic                        out_valid_r;

  logic [sbc_pkg::VTX_W-1:0]    a_r, b_r;
  logic [PW-1:0]                p_r;
  logic [HW-1:0]                hop_cur_r, hop_w_r;
  logic [31:0]                  path_cur_r, sw_r, dep_w_r, sv_r, dep_v_r;
  logic [VW-1:0]                nb_r, w_r;
  logic [sbc_pkg::SCORE_W-1:0]  score_w_r;
  logic [63:0]                  prod_r;
  logic [sbc_pkg::STATUS_W-1:0] res_status_r, out_status_r;
  logic [sbc_pkg::SCORE_W-1:0]  res_score_r, out_score_r;
  logic [sbc_pkg::COUNT_W-1:0]  res_reached_r, out_reached_r;

  // Memory ports.
  logic            head_we, lnk_we, hop_we, path_we, dep_we, ord_we, score_we;
  logic [VW-1:0]   head_wa, hop_wa, path_wa, dep_wa, ord_wa, score_wa, rd_v;
  logic [VW-1:0]   ord_ra;
  logic [EW-1:0]   lnk_wa, lnk_ra;
  logic [PW-1:0]   head_wd, next_wd, head_rd, next_rd;
  logic [sbc_pkg::VTX_W-1:0] tgt_wd, tgt_rd;
  logic [HW-1:0]   hop_wd, hop_rd;
  logic [31:0]     path_wd, path_rd, dep_wd, dep_rd;
  logic [VW-1:0]   ord_wd, ord_rd;
  logic [sbc_pkg::SCORE_W-1:0] score_wd, score_rd;

  logic                        div_start, div_done;
  logic [sbc_pkg::NUM_W-1:0]   div_num, div_quo;

  logic [sbc_pkg::COUNT_W-1:0] n_eff;
  logic                        in_fire, a_ok, b_ok, tgt_ok;
  logic                        discover, path_hit, pred_ok, init_last, out_free;
  logic [HW-1:0]               hop_new;
  logic [32:0]                 path_sum, dep_sum;
  logic [32:0]                 m_w;
  logic [31:0]                 mul_x, mul_y;
  logic [sbc_pkg::SCORE_W:0]   score_sum;
  logic [VW-1:0]               src_v;
  sbc_pkg::status_t            in_status;

  always_comb begin
    n_eff = (32'(vertex_count_r) > 32'(MAX_VERTICES)) ?
            sbc_pkg::COUNT_W'(MAX_VERTICES) : vertex_count_r;
    a_ok   = {1'b0, in_vertex_a} < n_eff;
    b_ok   = {1'b0, in_vertex_b} < n_eff;
    tgt_ok = {1'b0, tgt_rd} < n_eff;
    in_fire  = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
    src_v    = VW'(a_r);
    init_last = cnt_r == CNTW'(MAX_VERTICES - 1);

    // Range is checked before the self-loop test, which comes before the full test.
    priority if (in_cmd == sbc_pkg::CMD_ADD_EDGE && (!a_ok || !b_ok)) begin
      in_status = sbc_pkg::ST_RANGE;
    end else if (in_cmd == sbc_pkg::CMD_ADD_EDGE && in_vertex_a == in_vertex_b) begin
      in_status = sbc_pkg::ST_SELF_LOOP;
    end else if (in_cmd == sbc_pkg::CMD_ADD_EDGE && ec_r > PW'(MAX_LIST_ENTRIES - 2)) begin
      in_status = sbc_pkg::ST_FULL;
    end else if ((in_cmd == sbc_pkg::CMD_SOURCE || in_cmd == sbc_pkg::CMD_READ) && !a_ok) begin
      in_status = sbc_pkg::ST_RANGE;
    end else begin
      in_status = sbc_pkg::ST_OK;
    end

    discover = (hop_rd == HOP_NONE) && (tail_r < CNTW'(MAX_VERTICES));
    hop_new  = discover ? (hop_cur_r + HW'(1)) : hop_rd;
    path_hit = hop_new == (hop_cur_r + HW'(1));
    path_sum = {1'b0, path_rd} + {1'b0, path_cur_r};

    pred_ok = (hop_rd != HOP_NONE) && ((hop_rd + HW'(1)) == hop_w_r) && (sw_r != 32'd0);
    m_w     = sbc_pkg::DEP_ONE + {1'b0, dep_w_r};
    mul_x   = (state_r == sbc_pkg::S_R_SMUL) ? dep_w_r : sv_r;
    mul_y   = (state_r == sbc_pkg::S_R_SMUL) ? 32'(scale_r) : m_w[31:0];
    div_num = {1'b0, prod_r} + (m_w[32] ? {1'b0, sv_r, 32'd0} : {sbc_pkg::NUM_W{1'b0}});
    dep_sum = {1'b0, dep_v_r} + {1'b0, div_quo[31:0]};
    score_sum = {1'b0, score_w_r} + (sbc_pkg::SCORE_W + 1)'(prod_r[63:17]);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbc_pkg::S_INIT: if (init_last) state_nxt = sbc_pkg::S_IDLE;
      sbc_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (sbc_pkg::cmd_t'(in_cmd))
            sbc_pkg::CMD_ADD_EDGE: begin
              if (a_ok && b_ok && in_vertex_a != in_vertex_b &&
                  ec_r <= PW'(MAX_LIST_ENTRIES - 2)) state_nxt = sbc_pkg::S_E_WA;
              else state_nxt = sbc_pkg::S_OUT;
            end
            sbc_pkg::CMD_SOURCE: state_nxt = a_ok ? sbc_pkg::S_CLR : sbc_pkg::S_OUT;
            sbc_pkg::CMD_READ:   state_nxt = a_ok ? sbc_pkg::S_RD_W : sbc_pkg::S_OUT;
            sbc_pkg::CMD_NONE:   state_nxt = sbc_pkg::S_OUT;
            default:             state_nxt = sbc_pkg::S_OUT;
          endcase
        end
      end
      sbc_pkg::S_E_WA:   state_nxt = sbc_pkg::S_E_WB;
      sbc_pkg::S_E_WB:   state_nxt = sbc_pkg::S_OUT;
      sbc_pkg::S_RD_W:   state_nxt = sbc_pkg::S_OUT;
      sbc_pkg::S_CLR:    if (init_last) state_nxt = sbc_pkg::S_SEED;
      sbc_pkg::S_SEED:   state_nxt = sbc_pkg::S_B_POP;
      sbc_pkg::S_B_POP:  state_nxt = (cnt_r < tail_r) ? sbc_pkg::S_B_CUR : sbc_pkg::S_R_POP;
      sbc_pkg::S_B_CUR:  state_nxt = sbc_pkg::S_B_CURD;
      sbc_pkg::S_B_CURD: state_nxt = sbc_pkg::S_B_EDGE;
      sbc_pkg::S_B_EDGE: state_nxt = (p_r == '0) ? sbc_pkg::S_B_POP : sbc_pkg::S_B_NB;
      sbc_pkg::S_B_NB:   state_nxt = tgt_ok ? sbc_pkg::S_B_UPD : sbc_pkg::S_B_EDGE;
      sbc_pkg::S_B_UPD:  state_nxt = sbc_pkg::S_B_EDGE;
      sbc_pkg::S_R_POP:  state_nxt = (cnt_r == '0) ? sbc_pkg::S_OUT : sbc_pkg::S_R_W;
      sbc_pkg::S_R_W:    state_nxt = (ord_rd == src_v) ? sbc_pkg::S_R_POP : sbc_pkg::S_R_WD;
      sbc_pkg::S_R_WD:   state_nxt = sbc_pkg::S_R_EDGE;
      sbc_pkg::S_R_EDGE: state_nxt = (p_r == '0) ? sbc_pkg::S_R_SMUL : sbc_pkg::S_R_NB;
      sbc_pkg::S_R_NB:   state_nxt = tgt_ok ? sbc_pkg::S_R_VD : sbc_pkg::S_R_EDGE;
      sbc_pkg::S_R_VD:   state_nxt = pred_ok ? sbc_pkg::S_R_MUL : sbc_pkg::S_R_EDGE;
      sbc_pkg::S_R_MUL:  state_nxt = sbc_pkg::S_R_ADD;
      sbc_pkg::S_R_ADD:  state_nxt = sbc_pkg::S_R_DIV;
      sbc_pkg::S_R_DIV:  if (div_done) state_nxt = sbc_pkg::S_R_DEP;
      sbc_pkg::S_R_DEP:  state_nxt = sbc_pkg::S_R_EDGE;
      sbc_pkg::S_R_SMUL: state_nxt = sbc_pkg::S_R_SCW;
      sbc_pkg::S_R_SCW:  state_nxt = sbc_pkg::S_R_POP;
      sbc_pkg::S_OUT:    if (out_free) state_nxt = sbc_pkg::S_IDLE;
      default:           state_nxt = sbc_pkg::S_INIT;
    endcase
  end

  // Memory controls.
  always_comb begin
    head_we = 1'b0; head_wa = VW'(a_r); head_wd = PW'(ec_r + PW'(1));
    lnk_we = 1'b0; lnk_wa = EW'(ec_r); next_wd = head_rd; tgt_wd = b_r;
    hop_we = 1'b0; hop_wa = cnt_r[VW-1:0]; hop_wd = HOP_NONE;
    path_we = 1'b0; path_wa = cnt_r[VW-1:0]; path_wd = 32'd0;
    dep_we = 1'b0; dep_wa = cnt_r[VW-1:0]; dep_wd = 32'd0;
    ord_we = 1'b0; ord_wa = tail_r[VW-1:0]; ord_wd = nb_r;
    score_we = 1'b0; score_wa = cnt_r[VW-1:0]; score_wd = '0;
    div_start = 1'b0;
    lnk_ra = EW'(p_r - PW'(1));
    ord_ra = (state_r == sbc_pkg::S_R_POP) ? VW'(cnt_r - CNTW'(1)) : cnt_r[VW-1:0];
    rd_v   = VW'(a_r);
    unique case (state_r)
      sbc_pkg::S_INIT: begin
        head_we = 1'b1; head_wa = cnt_r[VW-1:0]; head_wd = '0;
        score_we = 1'b1;
        hop_we = 1'b1; path_we = 1'b1; dep_we = 1'b1;
      end
      sbc_pkg::S_IDLE: rd_v = VW'(in_vertex_a);
      sbc_pkg::S_E_WA: begin
        head_we = 1'b1; lnk_we = 1'b1;
        rd_v = VW'(b_r);
      end
      sbc_pkg::S_E_WB: begin
        head_we = 1'b1; head_wa = VW'(b_r); lnk_we = 1'b1; tgt_wd = a_r;
      end
      sbc_pkg::S_CLR: begin
        hop_we = 1'b1; path_we = 1'b1; dep_we = 1'b1;
      end
      sbc_pkg::S_SEED: begin
        hop_we = 1'b1; hop_wa = src_v; hop_wd = '0;
        path_we = 1'b1; path_wa = src_v; path_wd = 32'd1;
        ord_we = 1'b1; ord_wa = '0; ord_wd = src_v;
      end
      sbc_pkg::S_B_CUR, sbc_pkg::S_R_W: rd_v = ord_rd;
      sbc_pkg::S_B_NB, sbc_pkg::S_R_NB: rd_v = VW'(tgt_rd);
      sbc_pkg::S_B_UPD: begin
        hop_we = discover; hop_wa = nb_r; hop_wd = hop_new;
        ord_we = discover;
        path_we = path_hit; path_wa = nb_r;
        path_wd = path_sum[32] ? 32'hFFFF_FFFF : path_sum[31:0];
      end
      sbc_pkg::S_R_ADD: div_start = 1'b1;
      sbc_pkg::S_R_DEP: begin
        dep_we = 1'b1; dep_wa = nb_r;
        dep_wd = ((|div_quo[sbc_pkg::NUM_W-1:32]) || dep_sum[32]) ?
                 32'hFFFF_FFFF : dep_sum[31:0];
      end
      sbc_pkg::S_R_SCW: begin
        score_we = 1'b1; score_wa = w_r;
        score_wd = score_sum[sbc_pkg::SCORE_W] ? {sbc_pkg::SCORE_W{1'b1}} :
                   score_sum[sbc_pkg::SCORE_W-1:0];
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sbc_pkg::S_INIT;
      cnt_r          <= '0;
      tail_r         <= '0;
      ec_r           <= '0;
      out_valid_r    <= 1'b0;
      vertex_count_r <= sbc_pkg::VERTEX_COUNT_RST;
      scale_r        <= sbc_pkg::SCALE_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == sbc_pkg::CFG_VERTEX_COUNT) begin
          vertex_count_r <= cfg_data[sbc_pkg::COUNT_W-1:0];
        end else if (cfg_index == sbc_pkg::CFG_SCALE) begin
          scale_r <= cfg_data;
        end
      end
      if (state_r == sbc_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        sbc_pkg::S_INIT, sbc_pkg::S_CLR: cnt_r <= init_last ? '0 : cnt_r + CNTW'(1);
        sbc_pkg::S_IDLE: cnt_r <= '0;
        sbc_pkg::S_E_WA, sbc_pkg::S_E_WB: ec_r <= ec_r + PW'(1);
        sbc_pkg::S_SEED: begin
          cnt_r  <= '0;
          tail_r <= CNTW'(1);
        end
        sbc_pkg::S_B_POP: cnt_r <= (cnt_r < tail_r) ? cnt_r + CNTW'(1) : tail_r;
        sbc_pkg::S_B_UPD: if (discover) tail_r <= tail_r + CNTW'(1);
        sbc_pkg::S_R_POP: if (cnt_r != '0) cnt_r <= cnt_r - CNTW'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      sbc_pkg::S_IDLE: begin
        a_r <= in_vertex_a;
        b_r <= in_vertex_b;
        res_score_r   <= '0;
        res_reached_r <= '0;
        res_status_r  <= in_status;
      end
      sbc_pkg::S_RD_W: res_score_r <= score_rd;
      sbc_pkg::S_B_CUR: nb_r <= ord_rd;
      sbc_pkg::S_B_CURD: begin
        p_r        <= head_rd;
        hop_cur_r  <= hop_rd;
        path_cur_r <= path_rd;
      end
      sbc_pkg::S_B_NB, sbc_pkg::S_R_NB: begin
        p_r  <= next_rd;
        nb_r <= VW'(tgt_rd);
      end
      sbc_pkg::S_R_POP: res_reached_r <= sbc_pkg::COUNT_W'(tail_r);
      sbc_pkg::S_R_W: w_r <= ord_rd;
      sbc_pkg::S_R_WD: begin
        p_r       <= head_rd;
        hop_w_r   <= hop_rd;
        sw_r      <= path_rd;
        dep_w_r   <= dep_rd;
        score_w_r <= score_rd;
      end
      sbc_pkg::S_R_VD: begin
        sv_r    <= path_rd;
        dep_v_r <= dep_rd;
      end
      sbc_pkg::S_R_MUL, sbc_pkg::S_R_SMUL: prod_r <= mul_x * mul_y;
      sbc_pkg::S_OUT: begin
        if (out_free) begin
          out_status_r  <= res_status_r;
          out_score_r   <= res_score_r;
          out_reached_r <= res_reached_r;
        end
      end
      default: ;
    endcase
  end

  sbc_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(rd_v), .rd_data(head_rd));

  sbc_ram #(.WIDTH(PW), .DEPTH(MAX_LIST_ENTRIES)) u_next (
    .clk(clk), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(next_wd),
    .rd_addr(lnk_ra), .rd_data(next_rd));

  sbc_ram #(.WIDTH(sbc_pkg::VTX_W), .DEPTH(MAX_LIST_ENTRIES)) u_target (
    .clk(clk), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(tgt_wd),
    .rd_addr(lnk_ra), .rd_data(tgt_rd));

  sbc_ram #(.WIDTH(HW), .DEPTH(MAX_VERTICES)) u_hop (
    .clk(clk), .wr_en(hop_we), .wr_addr(hop_wa), .wr_data(hop_wd),
    .rd_addr(rd_v), .rd_data(hop_rd));

  sbc_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_path (
    .clk(clk), .wr_en(path_we), .wr_addr(path_wa), .wr_data(path_wd),
    .rd_addr(rd_v), .rd_data(path_rd));

  sbc_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_dep (
    .clk(clk), .wr_en(dep_we), .wr_addr(dep_wa), .wr_data(dep_wd),
    .rd_addr(rd_v), .rd_data(dep_rd));

  sbc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_order (
    .clk(clk), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
    .rd_addr(ord_ra), .rd_data(ord_rd));

  sbc_ram #(.WIDTH(sbc_pkg::SCORE_W), .DEPTH(MAX_VERTICES)) u_score (
    .clk(clk), .wr_en(score_we), .wr_addr(score_wa), .wr_data(score_wd),
    .rd_addr(rd_v), .rd_data(score_rd));

  sbc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(sw_r), .done(div_done), .quo(div_quo));

  assign in_ready          = state_r == sbc_pkg::S_IDLE;
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_score         = out_score_r;
  assign out_reached_count = out_reached_r;

endmodule

// File: verif/tb_sampled_betweenness_centrality.sv
`timescale 1ns / 1ps

module tb_sampled_betweenness_centrality;

  typedef struct {
    sbc_pkg::status_t status;
    logic [47:0]      score;
    logic [10:0]      reached;
  } bc_result_t;

  // Scoreboard: mirrors the graph, the per-source stores and the scores.
  class bc_scoreboard;
    bit [10:0]  vcount;
    bit [26:0]  scale;
    bit [13:0]  head[1024];
    bit [13:0]  nxt[8192];
    bit [9:0]   tgt[8192];
    int         entries;
    bit [31:0]  hop[1024];
    bit [31:0]  paths[1024];
    bit [31:0]  dep[1024];
    bit [9:0]   order[1024];
    bit [47:0]  score[1024];
    bc_result_t expected[$];
    int         errors;

    function void clear_all();
      vcount = 11'd1024;
      scale = 27'd65536;
      entries = 0;
      errors = 0;
      foreach (head[i]) begin
        head[i] = '0;
        score[i] = '0;
      end
    endfunction

    function bit [31:0] sat32(bit [31:0] x, longint unsigned y);
      bit [64:0] s;
      s = 65'(x) + 65'(y);
      return (s > 65'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
    endfunction

    function void link_entry(bit [9:0] from, bit [9:0] to);
      tgt[entries] = to;
      nxt[entries] = head[from];
      head[from] = 14'(entries + 1);
      entries++;
    endfunction

    function int walk_source(bit [9:0] src, int n);
      int qhead, tail, p;
      bit [9:0] cur, nb, w, v;
      longint unsigned m, sw, sv, term, inc, acc;
      qhead = 0;
      tail = 1;
      foreach (hop[k]) begin
        hop[k] = 32'hFFFFFFFF;
        paths[k] = '0;
        dep[k] = '0;
      end
      hop[src] = 32'd0;
      paths[src] = 32'd1;
      order[0] = src;
      while (qhead < tail) begin
        cur = order[qhead++];
        for (p = int'(head[cur]); p != 0; p = int'(nxt[p-1])) begin
          nb = tgt[p-1];
          if (nb >= n) continue;
          if (hop[nb] == 32'hFFFFFFFF && tail < 1024) begin
            hop[nb] = hop[cur] + 32'd1;
            order[tail++] = nb;
          end
          if (hop[nb] == hop[cur] + 32'd1) paths[nb] = sat32(paths[nb], paths[cur]);
        end
      end
      // Reverse pass: predecessors are the neighbors one hop closer.
      for (int k = tail; k > 0; k--) begin
        w = order[k-1];
        if (w == src) continue;
        sw = paths[w];
        m = 64'd65536 + dep[w];
        for (p = int'(head[w]); p != 0; p = int'(nxt[p-1])) begin
          v = tgt[p-1];
          if (v >= n || hop[v] == 32'hFFFFFFFF) continue;
          if (hop[v] + 32'd1 != hop[w] || sw == 0) continue;
          sv = paths[v];
          term = (m / sw) * sv + ((m % sw) * sv) / sw;
          dep[v] = sat32(dep[v], term);
        end
        inc = dep[w];
        inc = (inc * scale) >> 17;
        acc = score[w] + inc;
        score[w] = (acc > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : acc[47:0];
      end
      return tail;
    endfunction

    function void note_item(sbc_pkg::cmd_t cmd, bit [9:0] a, bit [9:0] b);
      bc_result_t r;
      int n;
      n = (vcount > 1024) ? 1024 : int'(vcount);
      r.status = sbc_pkg::ST_OK;
      r.score = '0;
      r.reached = '0;
      case (cmd)
        sbc_pkg::CMD_ADD_EDGE: begin
          if (a >= n || b >= n) r.status = sbc_pkg::ST_RANGE;
          else if (a == b) r.status = sbc_pkg::ST_SELF_LOOP;
          else if (entries > 8190) r.status = sbc_pkg::ST_FULL;
          else begin
            link_entry(a, b);
            link_entry(b, a);
          end
        end
        sbc_pkg::CMD_SOURCE: begin
          if (a >= n) r.status = sbc_pkg::ST_RANGE;
          else r.reached = 11'(walk_source(a, n));
        end
        sbc_pkg::CMD_READ: begin
          if (a >= n) r.status = sbc_pkg::ST_RANGE;
          else r.score = score[a];
        end
        default: ;
      endcase
      expected.insert(expected.size(), r);
    endfunction

    function void check_result(logic [1:0] st, logic [47:0] sc, logic [10:0] rc);
      bc_result_t r;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d score %0h reached %0d",
                                   st, sc, rc);
        return;
      end
      r = expected.pop_front();
      if (st !== r.status || sc !== r.score || rc !== r.reached) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d score %0h/%0h reached %0d/%0d (exp/act)",
                   r.status, st, r.score, sc, r.reached, rc);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [9:0]  in_vertex_a;
  logic [9:0]  in_vertex_b;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [47:0] out_score;
  logic [10:0] out_reached_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [26:0] cfg_data;

  bc_scoreboard sb;
  bit quiet;
  bit hold_req;

  sampled_betweenness_centrality i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_score         (out_score),
    .out_reached_count (out_reached_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_score, out_reached_count);
  end

  task automatic send_item(sbc_pkg::cmd_t cmd, bit [9:0] a, bit [9:0] b);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, a, b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [26:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sbc_pkg::CFG_VERTEX_COUNT) sb.vcount = value[10:0];
    else sb.scale = value;
  endtask

  task automatic random_items(int count, int n);
    int hi, r;
    bit [9:0] a, b;
    hi = ((n < 48) ? n : 48) - 1;
    repeat (count) begin
      r = $urandom_range(0, 99);
      a = 10'($urandom_range(0, hi));
      b = 10'($urandom_range(0, hi));
      if ($urandom_range(0, 9) == 0) a = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) == 0) b = 10'($urandom_range(0, 1023));
      if (r < 55) send_item(sbc_pkg::CMD_ADD_EDGE, a, b);
      else if (r < 72) send_item(sbc_pkg::CMD_SOURCE, a, b);
      else if (r < 95) send_item(sbc_pkg::CMD_READ, a, b);
      else send_item(sbc_pkg::CMD_NONE, 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)));
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    int n;
    sb = new();
    sb.clear_all();
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= sbc_pkg::CMD_ADD_EDGE;
    in_vertex_a <= '0;
    in_vertex_b <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sbc_pkg::CFG_VERTEX_COUNT;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset configuration.
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd0, 10'd1023);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd1023, 10'd1023);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd5, 10'd5);
    send_item(sbc_pkg::CMD_SOURCE, 10'd1023, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd0, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd1023, 10'd1023);
    send_item(sbc_pkg::CMD_NONE, 10'd1023, 10'd1023);

    // Small graph with a duplicate edge, an unreachable vertex and a shrunk count.
    write_reg(sbc_pkg::CFG_VERTEX_COUNT, 27'd8);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd0, 10'd8);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd9, 10'd1);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd0, 10'd1);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd1, 10'd2);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd1, 10'd2);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd0, 10'd3);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd3, 10'd2);
    send_item(sbc_pkg::CMD_ADD_EDGE, 10'd2, 10'd4);
    send_item(sbc_pkg::CMD_SOURCE, 10'd9, 10'd0);
    send_item(sbc_pkg::CMD_SOURCE, 10'd0, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd1, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd12, 10'd0);
    write_reg(sbc_pkg::CFG_SCALE, 27'd67108864);
    send_item(sbc_pkg::CMD_SOURCE, 10'd4, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd2, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd7, 10'd0);

    // Random phases over several settings; the first one includes a long hold-off
    // while items keep coming.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: n = 32;
        1: n = 1;
        2: n = 2;
        3: n = 1024;
        default: n = $urandom_range(3, 48);
      endcase
      write_reg(sbc_pkg::CFG_VERTEX_COUNT, 27'(n));
      write_reg(sbc_pkg::CFG_SCALE,
                (ph == 1) ? 27'd65536 : 27'($urandom_range(65536, 67108864)));
      if (ph == 0) hold_req = 1'b1;
      random_items(5, n);
    end

    // Last part without idling: a chain of triple edges, so path counts
    // saturate at the far end.
    quiet = 1'b1;
    write_reg(sbc_pkg::CFG_VERTEX_COUNT, 27'd1024);
    for (int l = 0; l < 21; l++)
      repeat (3) send_item(sbc_pkg::CMD_ADD_EDGE, 10'(100 + l), 10'(101 + l));
    send_item(sbc_pkg::CMD_SOURCE, 10'd100, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd110, 10'd0);
    send_item(sbc_pkg::CMD_READ, 10'd120, 10'd0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sbc_pkg.sv
rtl/sbc_ram.sv
rtl/sbc_div.sv
rtl/sampled_betweenness_centrality.sv
verif/tb_sampled_betweenness_centrality.sv
